// ===== sv/lfu_cache_with_lru_tiebreak_top_defines.svh =====
// Assertion macros used by the LFU cache RTL.
`ifndef LFU_CACHE_WITH_LRU_TIEBREAK_TOP_DEFINES_SVH
`define LFU_CACHE_WITH_LRU_TIEBREAK_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define LFUC_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define LFUC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/lfuc_pkg.sv =====
// Package with sizes, codes and record types of the LFU cache.
package lfuc_pkg;

   localparam int ENTRIES    = 16;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = 16;
   localparam int CAP_BITS   = 5;

   localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_BITS = IDX_BITS;
   localparam int OCC_BITS  = $clog2(ENTRIES + 1);
   localparam int CMP_BITS  = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;

   localparam logic [CMP_BITS-1:0]   ENTRIES_CMP = CMP_BITS'(ENTRIES);
   localparam logic [OCC_BITS-1:0]   ENTRIES_OCC = OCC_BITS'(ENTRIES);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX   = '1;
   localparam logic [CAP_BITS-1:0]   CAP_RESET   = CAP_BITS'(16);

   // Request action codes
   localparam logic ACT_GET = 1'b0;
   localparam logic ACT_PUT = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } state_type;

   typedef enum logic [1:0] {
      UPD_NONE,
      UPD_TOUCH,
      UPD_INSERT
   } upd_op_type;

   // Record handed from cell to cell during a search wave
   typedef struct packed {
      logic                  found;
      logic [IDX_BITS-1:0]   found_idx;
      logic [RANK_BITS-1:0]  found_rank;
      logic [VALUE_BITS-1:0] found_value;
      logic                  vic_have;
      logic [IDX_BITS-1:0]   vic_idx;
      logic [COUNT_BITS-1:0] vic_count;
      logic [RANK_BITS-1:0]  vic_rank;
      logic [KEY_BITS-1:0]   vic_key;
      logic                  free_have;
      logic [IDX_BITS-1:0]   free_idx;
   } scan_type;

   // Update command broadcast to every cell
   typedef struct packed {
      upd_op_type            op;
      logic [IDX_BITS-1:0]   tgt_idx;
      logic [RANK_BITS-1:0]  ref_rank;
      logic                  write_value;
      logic [VALUE_BITS-1:0] value;
      logic [KEY_BITS-1:0]   key;
      logic                  evict;
      logic [IDX_BITS-1:0]   vic_idx;
      logic [RANK_BITS-1:0]  vic_rank;
   } upd_type;

endpackage

// ===== sv/lfuc_if.sv =====
// Request and response channel interfaces of the LFU cache.
interface lfuc_req_if import lfuc_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic        [KEY_BITS-1:0]   key;
   logic signed [VALUE_BITS-1:0] value;

   modport source(output valid, action, key, value, input ready);
   modport sink(input valid, action, key, value, output ready);
endinterface

interface lfuc_rsp_if import lfuc_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         hit;
   logic signed [VALUE_BITS-1:0] read_value;
   logic                         evicted;
   logic        [KEY_BITS-1:0]   evicted_key;

   modport source(output valid, hit, read_value, evicted, evicted_key, input ready);
   modport sink(input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

// ===== sv/lfuc_cell.sv =====
// One cache entry: holds its key, value, use count and recency rank.
module lfuc_cell import lfuc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [IDX_BITS-1:0] cell_idx,
   input  logic [KEY_BITS-1:0] req_key,
   input  logic                wave_in,
   input  scan_type            carry_in,
   output logic                wave_out,
   output scan_type            carry_out,
   input  upd_type             upd
);

   logic                  valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [RANK_BITS-1:0]  rank_ff, rank_in;
   logic                  wave_ff;
   scan_type              carry_ff, carry_next;

   logic match, better, is_tgt, is_vic, rank_dec;

   // Fold this entry into the passing search record
   always_comb begin
      carry_next = carry_in;
      match      = valid_ff && (key_ff == req_key);
      better     = !carry_in.vic_have || (count_ff < carry_in.vic_count) ||
                   ((count_ff == carry_in.vic_count) && (rank_ff > carry_in.vic_rank));
      if (match && !carry_in.found) begin
         carry_next.found       = 1'b1;
         carry_next.found_idx   = cell_idx;
         carry_next.found_rank  = rank_ff;
         carry_next.found_value = value_ff;
      end
      if (valid_ff && better) begin
         carry_next.vic_have  = 1'b1;
         carry_next.vic_idx   = cell_idx;
         carry_next.vic_count = count_ff;
         carry_next.vic_rank  = rank_ff;
         carry_next.vic_key   = key_ff;
      end
      if (!valid_ff && !carry_in.free_have) begin
         carry_next.free_have = 1'b1;
         carry_next.free_idx  = cell_idx;
      end
   end

   // Advance the wave one cell per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         wave_ff <= 1'b0;
      end else begin
         wave_ff <= wave_in;
      end
      if (wave_in) begin
         carry_ff <= carry_next;
      end
   end

   assign wave_out  = wave_ff;
   assign carry_out = carry_ff;

   // Apply the broadcast update to this entry
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      count_in = count_ff;
      rank_in  = rank_ff;
      is_tgt   = (upd.tgt_idx == cell_idx);
      is_vic   = upd.evict && (upd.vic_idx == cell_idx);
      rank_dec = upd.evict && (rank_ff > upd.vic_rank);
      case (upd.op)
         UPD_TOUCH: begin
            if (is_tgt) begin
               if (count_ff != COUNT_MAX) begin
                  count_in = count_ff + COUNT_BITS'(1);
               end
               rank_in = '0;
               if (upd.write_value) begin
                  value_in = upd.value;
               end
            end else if (valid_ff && (rank_ff < upd.ref_rank)) begin
               rank_in = rank_ff + RANK_BITS'(1);
            end
         end
         UPD_INSERT: begin
            if (is_tgt) begin
               valid_in = 1'b1;
               key_in   = upd.key;
               value_in = upd.value;
               count_in = COUNT_BITS'(1);
               rank_in  = '0;
            end else if (is_vic) begin
               valid_in = 1'b0;
            end else if (valid_ff) begin
               rank_in = rank_ff - RANK_BITS'(rank_dec) + RANK_BITS'(1);
            end
         end
         default: begin
         end
      endcase
   end

   // Hold entry state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      key_ff   <= key_in;
      value_ff <= value_in;
      count_ff <= count_in;
      rank_ff  <= rank_in;
   end

endmodule

// ===== sv/lfuc_ctrl.sv =====
// Sequencer: takes requests, launches the search wave, decides and answers.
`include "lfu_cache_with_lru_tiebreak_top_defines.svh"

module lfuc_ctrl import lfuc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   lfuc_req_if.sink            req,
   lfuc_rsp_if.source          rsp,
   input  logic                csr_wr_en,
   input  logic [CAP_BITS-1:0] csr_wr_data,
   output logic [KEY_BITS-1:0] req_key,
   output logic                wave_start,
   output scan_type            carry_init,
   input  logic                wave_done,
   input  scan_type            scan_result,
   output upd_type             upd
);

   state_type             state_ff, state_in;
   logic [CAP_BITS-1:0]   cap_ff;
   logic [OCC_BITS-1:0]   occ_ff, occ_in;
   logic                  launch_ff;
   logic                  act_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   scan_type              scan_ff;

   logic                  rsp_valid_ff;
   logic                  hit_ff, hit_in;
   logic [VALUE_BITS-1:0] rdval_ff, rdval_in;
   logic                  evicted_ff, evicted_in;
   logic [KEY_BITS-1:0]   evkey_ff, evkey_in;

   logic                  accept, load;
   logic [CMP_BITS-1:0]   cap_eff;
   logic                  need_evict, have_slot;
   logic [IDX_BITS-1:0]   ins_idx;

   assign accept     = req.valid && req.ready;
   assign req.ready  = (state_ff == ST_IDLE);
   assign req_key    = key_ff;
   assign wave_start = launch_ff;
   assign carry_init = '0;

   // Clamp capacity to the number of cells
   assign cap_eff = (CMP_BITS'(cap_ff) > ENTRIES_CMP) ? ENTRIES_CMP : CMP_BITS'(cap_ff);

   // Pick the insert slot: first free cell, counting the victim's cell as free when an eviction is needed
   always_comb begin
      need_evict = (CMP_BITS'(occ_ff) >= cap_eff) && scan_ff.vic_have;
      have_slot  = need_evict || scan_ff.free_have;
      if (need_evict) begin
         ins_idx = (scan_ff.free_have && (scan_ff.free_idx < scan_ff.vic_idx)) ?
                   scan_ff.free_idx : scan_ff.vic_idx;
      end else begin
         ins_idx = scan_ff.free_idx;
      end
   end

   // Next state, update command and result
   always_comb begin
      state_in   = state_ff;
      occ_in     = occ_ff;
      load       = 1'b0;
      hit_in     = 1'b0;
      rdval_in   = '0;
      evicted_in = 1'b0;
      evkey_in   = '0;
      upd        = '0;
      upd.op     = UPD_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (wave_done) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            if (!rsp_valid_ff || rsp.ready) begin
               load     = 1'b1;
               state_in = ST_IDLE;
               if (act_ff == ACT_GET) begin
                  if (scan_ff.found) begin
                     hit_in       = 1'b1;
                     rdval_in     = scan_ff.found_value;
                     upd.op       = UPD_TOUCH;
                     upd.tgt_idx  = scan_ff.found_idx;
                     upd.ref_rank = scan_ff.found_rank;
                  end
               end else if (cap_eff != '0) begin
                  if (scan_ff.found) begin
                     hit_in          = 1'b1;
                     upd.op          = UPD_TOUCH;
                     upd.tgt_idx     = scan_ff.found_idx;
                     upd.ref_rank    = scan_ff.found_rank;
                     upd.write_value = 1'b1;
                     upd.value       = value_ff;
                  end else begin
                     evicted_in = need_evict;
                     evkey_in   = need_evict ? scan_ff.vic_key : '0;
                     if (have_slot) begin
                        upd.op       = UPD_INSERT;
                        upd.tgt_idx  = ins_idx;
                        upd.value    = value_ff;
                        upd.key      = key_ff;
                        upd.evict    = need_evict;
                        upd.vic_idx  = scan_ff.vic_idx;
                        upd.vic_rank = scan_ff.vic_rank;
                     end
                     occ_in = occ_ff - OCC_BITS'(need_evict) + OCC_BITS'(have_slot);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         occ_ff       <= '0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         occ_ff    <= occ_in;
         launch_ff <= accept;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the transaction, the search record and the response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff   <= req.action;
         key_ff   <= req.key;
         value_ff <= req.value;
      end
      if (wave_done) begin
         scan_ff <= scan_result;
      end
      if (load) begin
         hit_ff     <= hit_in;
         rdval_ff   <= rdval_in;
         evicted_ff <= evicted_in;
         evkey_ff   <= evkey_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.hit         = hit_ff;
   assign rsp.read_value  = rdval_ff;
   assign rsp.evicted     = evicted_ff;
   assign rsp.evicted_key = evkey_ff;

   `LFUC_ASSERT_IMPL(a_wave_in_scan, wave_done, state_ff == ST_SCAN, "search wave ended outside scan")
   `LFUC_ASSERT_IMPL(a_occ_bound, 1'b1, occ_ff <= ENTRIES_OCC, "occupancy above cell count")
   `LFUC_ASSERT_NEXT(a_load_shows, load, rsp.valid, "decided transaction not presented")
   `LFUC_ASSERT_NEXT(a_accept_launch, accept, launch_ff && (state_ff == ST_SCAN), "wave not launched")

endmodule

// ===== sv/lfu_cache_with_lru_tiebreak_top.sv =====
// A request enters the cache when the sequencer is idle. A search wave then walks
// the row of entry cells one cell per clock, gathering the matching entry, the
// eviction candidate (lowest use count, oldest on ties) and the first free cell;
// the apply state then updates all cells and loads the response register once any
// earlier response is taken. The response register frees the input side once
// loaded, and not before, so the next request may enter while a response waits
// to be taken. The user must write capacity through csr_wr_en/csr_wr_data only
// while the block is idle; the block itself does not enforce this.
module lfu_cache_with_lru_tiebreak_top import lfuc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   lfuc_req_if.sink            req_chan,
   lfuc_rsp_if.source          rsp_chan,
   input  logic                csr_wr_en,
   input  logic [CAP_BITS-1:0] csr_wr_data
);

   logic [KEY_BITS-1:0] req_key;
   logic                wave [ENTRIES+1];
   scan_type            carry [ENTRIES+1];
   upd_type             upd;

   // Sequencer
   lfuc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_key     (req_key),
      .wave_start  (wave[0]),
      .carry_init  (carry[0]),
      .wave_done   (wave[ENTRIES]),
      .scan_result (carry[ENTRIES]),
      .upd         (upd)
   );

   // Row of entry cells, each passing the search record to its neighbor
   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lfuc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_idx  (IDX_BITS'(i)),
         .req_key   (req_key),
         .wave_in   (wave[i]),
         .carry_in  (carry[i]),
         .wave_out  (wave[i+1]),
         .carry_out (carry[i+1]),
         .upd       (upd)
      );
   end

endmodule
